// ===== rtl/toc_pkg.sv =====
package toc_pkg;

   typedef enum logic [3:0] {
      MODE_NONE        = 4'd0,
      MODE_HEIGHT      = 4'd1,
      MODE_SLOPE       = 4'd2,
      MODE_BAND        = 4'd3,
      MODE_DISTANCE    = 4'd4,
      MODE_ROUGHNESS   = 4'd5,
      MODE_ASPECT      = 4'd6,
      MODE_ERODIBILITY = 4'd7,
      MODE_SOIL        = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      BAND_WATER     = 2'd0,
      BAND_LOWLAND   = 2'd1,
      BAND_HILLS     = 2'd2,
      BAND_MOUNTAINS = 2'd3
   } band_type;

   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   localparam int          CSR_ADDR_W  = 3;
   localparam logic        REG_MODE    = 1'b0;
   localparam logic        REG_DMAX    = 1'b1;
   localparam logic [15:0] DMAX_RESET  = 16'd16;

   localparam logic [7:0]  ALPHA_RAMP  = 8'd180;
   localparam logic [7:0]  ALPHA_FLAT  = 8'd200;

   // floor(d / 3) == (d * 21846) >> 16 for 0 <= d < 32768
   localparam logic [15:0] SOIL_RECIP  = 16'd21846;
   localparam int          SOIL_SHIFT  = 16;

   function automatic pixel_type band_pixel(input logic [1:0] code);
      pixel_type p;
      case (code)
         BAND_WATER:     p = '{8'd30,  8'd60,  8'd180, ALPHA_FLAT};
         BAND_LOWLAND:   p = '{8'd120, 8'd180, 8'd80,  ALPHA_FLAT};
         BAND_HILLS:     p = '{8'd200, 8'd170, 8'd80,  ALPHA_FLAT};
         BAND_MOUNTAINS: p = '{8'd180, 8'd180, 8'd190, ALPHA_FLAT};
         default:        p = '{8'd180, 8'd180, 8'd190, ALPHA_FLAT};
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/toc_channels.sv =====
interface toc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] height_value;
   logic signed [15:0] slope_value;
   logic [1:0]         band_code;
   logic [15:0]        ocean_distance;
   logic signed [15:0] roughness_value;
   logic signed [15:0] aspect_angle;
   logic signed [15:0] erodibility_value;
   logic signed [15:0] soil_depth_value;

   modport source (
      output valid, height_value, slope_value, band_code, ocean_distance,
             roughness_value, aspect_angle, erodibility_value, soil_depth_value,
      input  ready
   );
   modport sink (
      input  valid, height_value, slope_value, band_code, ocean_distance,
             roughness_value, aspect_angle, erodibility_value, soil_depth_value,
      output ready
   );
endinterface

interface toc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== rtl/terrain_overlay_colorizer.sv =====
// terrain overlay colorizer
// req_ch carries one terrain tile per word; rsp_ch returns one RGBA overlay
// pixel for it, or nothing when overlay_mode is none or an unused code.
// csr port (APB style, pready tied high): 0x0 overlay_mode, 0x4 distance_max;
// the mode and distance maximum are sampled as a word enters the pipeline.
// pipeline: input, prep and seed stages, then the bit-per-stage restoring
// divider shared by the distance ramp and the hue wheel, then a color stage.
// throughput: one word per cycle while rsp_ch.ready is high, in every mode.
// stalls: each stage holds its word while the next stage is full and stalled;
// empty stages keep filling, so req_ch.ready drops only when every stage
// holds a word and rsp_ch.ready is low. rsp_ch.ready high implies
// req_ch.ready high. nothing is lost or repeated across a stall.
// reset: synchronous, active high; empties the pipeline, overlay_mode
// returns to none and distance_max to 16.
module terrain_overlay_colorizer #(
   parameter int FRAC_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   toc_req_if.sink                          req_ch,
   toc_rsp_if.source                        rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [toc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import toc_pkg::*;

   localparam int              F       = FRAC_BITS;
   localparam int              T_W     = F + 1;
   localparam logic [T_W-1:0]  ONE_FX  = T_W'(1) << F;
   localparam longint          PI_Q28  = 64'sd843314857;
   localparam longint          PI_L    = (PI_Q28 + (64'sd1 <<< (27 - F))) >>> (28 - F);
   localparam int              D_W     = 16;
   localparam logic [D_W-1:0]  PI_FX   = D_W'(PI_L);
   localparam int              U_W     = $clog2(2 * PI_L + 1);
   localparam int              H_W     = $clog2(6 * PI_L + 1);
   localparam int              SUM_W   = ((U_W > 16) ? U_W : 16) + 2;
   localparam int              P_W     = F + 10;
   localparam int              SQ_W    = 14;
   localparam int              N_STG   = F + 4;
   localparam int              S_DIV   = 3;
   localparam int              S_OUT   = N_STG - 1;

   localparam logic signed [15:0]      ONE_S   = 16'(1 << F);
   localparam logic signed [SUM_W-1:0] TWO_PI  = SUM_W'(2 * PI_L);

   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] height;
      logic signed [15:0] slope;
      logic [1:0]         band;
      logic [15:0]        ocean;
      logic signed [15:0] rough;
      logic signed [15:0] aspect;
      logic signed [15:0] erod;
      logic signed [15:0] soil;
      logic [15:0]        dmax;
   } in_type;

   typedef struct packed {
      mode_type        mode;
      logic [T_W-1:0]  t;
      logic [SQ_W-1:0] soil_q;
      logic [1:0]      band;
      logic [U_W-1:0]  u;
      logic [15:0]     ocean;
      logic [15:0]     dmax;
      logic            sat;
      logic            dzero;
   } prep_type;

   typedef struct packed {
      mode_type        mode;
      logic [T_W-1:0]  t;
      logic [1:0]      band;
      logic [2:0]      sec;
      logic [D_W-1:0]  rem;
      logic [D_W-1:0]  div;
      logic [F-1:0]    quo;
      logic            use_quo;
   } div_type;

   logic [3:0]       mode_ff;
   logic [15:0]      dmax_ff;
   logic [N_STG-1:0] v_ff;
   logic [N_STG-1:0] v_in;
   logic [N_STG-1:0] go;
   logic             entry_ok;

   in_type    in_ff;
   prep_type  prep_ff;
   prep_type  prep_in;
   div_type   seed_ff;
   div_type   seed_in;
   div_type   div_ff [F];
   pixel_type out_ff;
   pixel_type out_in;

   function automatic logic [7:0] scale_fx(input logic [T_W-1:0] t, input logic [7:0] k);
      logic [P_W-1:0] p;
      p = P_W'(t) * P_W'(k);
      return p[F+7:F];
   endfunction

   function automatic logic [7:0] lerp_fx(input logic [T_W-1:0] t, input logic [7:0] a,
                                          input logic [7:0] b);
      logic [P_W-1:0] p;
      p = P_W'(a) * P_W'(ONE_FX - t) + P_W'(b) * P_W'(t);
      return p[F+7:F];
   endfunction

   // csr port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         dmax_ff <= DMAX_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_MODE: mode_ff <= csr_pwdata[3:0];
            REG_DMAX: dmax_ff <= csr_pwdata[15:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MODE: csr_prdata = {28'd0, mode_ff};
         REG_DMAX: csr_prdata = {16'd0, dmax_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // pipeline flow control
   for (genvar g = 0; g < N_STG; g++) begin : g_go
      assign go[g] = rsp_ch.ready || !(&v_ff[N_STG-1:g]);
   end

   assign entry_ok     = req_ch.valid && (mode_ff != MODE_NONE) && (mode_ff <= MODE_SOIL);
   assign req_ch.ready = go[0];
   assign v_in         = (go & {v_ff[N_STG-2:0], entry_ok}) | (~go & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (go[0]) begin
         in_ff.mode   <= mode_type'(mode_ff);
         in_ff.height <= req_ch.height_value;
         in_ff.slope  <= req_ch.slope_value;
         in_ff.band   <= req_ch.band_code;
         in_ff.ocean  <= req_ch.ocean_distance;
         in_ff.rough  <= req_ch.roughness_value;
         in_ff.aspect <= req_ch.aspect_angle;
         in_ff.erod   <= req_ch.erodibility_value;
         in_ff.soil   <= req_ch.soil_depth_value;
         in_ff.dmax   <= dmax_ff;
      end
   end

   // prep stage: clamp to unit range, soil divide by three, aspect offset
   always_comb begin
      logic signed [15:0]      sel;
      logic [29:0]             sp;
      logic signed [SUM_W-1:0] sum;
      case (in_ff.mode)
         MODE_SLOPE:       sel = in_ff.slope;
         MODE_ROUGHNESS:   sel = in_ff.rough;
         MODE_ERODIBILITY: sel = in_ff.erod;
         default:          sel = in_ff.height;
      endcase
      sp  = 30'(in_ff.soil[14:0]) * 30'(SOIL_RECIP);
      sum = SUM_W'(in_ff.aspect) + SUM_W'(PI_L);

      prep_in.mode = in_ff.mode;
      if (sel < 0) begin
         prep_in.t = '0;
      end else if (sel > ONE_S) begin
         prep_in.t = ONE_FX;
      end else begin
         prep_in.t = T_W'(sel);
      end
      prep_in.soil_q = (in_ff.soil <= 0) ? '0 : sp[SOIL_SHIFT +: SQ_W];
      if (sum < 0) begin
         prep_in.u = '0;
      end else if (sum > TWO_PI) begin
         prep_in.u = U_W'(TWO_PI);
      end else begin
         prep_in.u = U_W'(sum);
      end
      prep_in.band  = in_ff.band;
      prep_in.ocean = in_ff.ocean;
      prep_in.dmax  = in_ff.dmax;
      prep_in.sat   = in_ff.ocean >= in_ff.dmax;
      prep_in.dzero = in_ff.dmax == '0;
   end

   always_ff @(posedge clock) begin
      if (go[1]) begin
         prep_ff <= prep_in;
      end
   end

   // seed stage: hue sector, divider operands and soil clamp
   always_comb begin
      logic [H_W-1:0] h3;
      logic [H_W-1:0] base;
      logic [2:0]     k;
      h3   = H_W'({prep_ff.u, 1'b0}) + H_W'(prep_ff.u);
      k    = '0;
      base = '0;
      for (int j = 1; j <= 6; j++) begin
         if (h3 >= H_W'(j * PI_L)) begin
            k    = 3'(j);
            base = H_W'(j * PI_L);
         end
      end

      seed_in.mode    = prep_ff.mode;
      seed_in.band    = prep_ff.band;
      seed_in.sec     = (k == 3'd6) ? SEC_RED : k;
      seed_in.quo     = '0;
      seed_in.rem     = '0;
      seed_in.div     = '0;
      seed_in.use_quo = 1'b0;
      seed_in.t       = prep_ff.t;
      case (prep_ff.mode)
         MODE_DISTANCE: begin
            seed_in.rem     = prep_ff.ocean;
            seed_in.div     = prep_ff.dmax;
            seed_in.use_quo = !prep_ff.sat && !prep_ff.dzero;
            seed_in.t       = prep_ff.dzero ? '0 : ONE_FX;
         end
         MODE_ASPECT: begin
            seed_in.rem     = D_W'(h3 - base);
            seed_in.div     = PI_FX;
            seed_in.use_quo = 1'b1;
         end
         MODE_SOIL: begin
            seed_in.t = (16'(prep_ff.soil_q) > 16'(ONE_FX)) ? ONE_FX : T_W'(prep_ff.soil_q);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (go[2]) begin
         seed_ff <= seed_in;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar g = 0; g < F; g++) begin : g_div
      div_type      src;
      div_type      div_in;
      logic [D_W:0] r2;
      logic         q_bit;

      if (g == 0) begin : g_first
         assign src = seed_ff;
      end else begin : g_next
         assign src = div_ff[g-1];
      end

      always_comb begin
         r2         = {src.rem, 1'b0};
         q_bit      = r2 >= {1'b0, src.div};
         div_in     = src;
         div_in.rem = q_bit ? D_W'(r2 - {1'b0, src.div}) : r2[D_W-1:0];
         div_in.quo = {src.quo[F-2:0], q_bit};
      end

      always_ff @(posedge clock) begin
         if (go[S_DIV+g]) begin
            div_ff[g] <= div_in;
         end
      end
   end

   // color stage
   always_comb begin
      div_type        d;
      logic [T_W-1:0] t;
      logic [T_W-1:0] f;
      logic [7:0]     up;
      logic [7:0]     dn;
      logic [7:0]     g;
      d  = div_ff[F-1];
      f  = {1'b0, d.quo};
      t  = d.use_quo ? f : d.t;
      up = scale_fx(f, 8'd255);
      dn = scale_fx(ONE_FX - f, 8'd255);
      g  = scale_fx(t, 8'd255);
      case (d.mode)
         MODE_HEIGHT: out_in = '{g, g, g, ALPHA_RAMP};
         MODE_SLOPE, MODE_ROUGHNESS:
            out_in = '{g, scale_fx(t, 8'd230), scale_fx(ONE_FX - t, 8'd20), ALPHA_RAMP};
         MODE_BAND: out_in = band_pixel(d.band);
         MODE_DISTANCE:
            out_in = '{scale_fx(t, 8'd220) + 8'd20, scale_fx(ONE_FX - t, 8'd220) + 8'd20,
                       8'd30, ALPHA_RAMP};
         MODE_ASPECT: begin
            case (d.sec)
               SEC_RED:     out_in = '{8'd255, up, 8'd0, ALPHA_RAMP};
               SEC_YELLOW:  out_in = '{dn, 8'd255, 8'd0, ALPHA_RAMP};
               SEC_GREEN:   out_in = '{8'd0, 8'd255, up, ALPHA_RAMP};
               SEC_CYAN:    out_in = '{8'd0, dn, 8'd255, ALPHA_RAMP};
               SEC_BLUE:    out_in = '{up, 8'd0, 8'd255, ALPHA_RAMP};
               default:     out_in = '{8'd255, 8'd0, dn, ALPHA_RAMP};
            endcase
         end
         MODE_ERODIBILITY:
            out_in = '{lerp_fx(t, 8'd40, 8'd200), lerp_fx(t, 8'd180, 8'd80),
                       lerp_fx(t, 8'd60, 8'd60), ALPHA_FLAT};
         MODE_SOIL:
            out_in = '{lerp_fx(t, 8'd220, 8'd80), lerp_fx(t, 8'd200, 8'd60),
                       lerp_fx(t, 8'd140, 8'd30), ALPHA_FLAT};
         default: out_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (go[S_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = v_ff[S_OUT];
   assign rsp_ch.red   = out_ff.red;
   assign rsp_ch.green = out_ff.green;
   assign rsp_ch.blue  = out_ff.blue;
   assign rsp_ch.alpha = out_ff.alpha;

endmodule

// ===== rtl/toc_checker.sv =====
module toc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_alpha
);
   import toc_pkg::*;

   logic req_word;
   assign req_word = req_valid && req_ready;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_red, rsp_green, rsp_blue, rsp_alpha}))
      else $error("rsp word changed while stalled");

   // pipeline empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // a draining output never blocks the input side
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req blocked while rsp side drains");

   // only the two opacity levels are produced
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alpha == ALPHA_RAMP || rsp_alpha == ALPHA_FLAT))
      else $error("bad alpha on rsp word");

   // an accepted word never arrives without ready
   a_accept_ready: assert property (@(posedge clock) disable iff (reset)
      req_word |-> req_ready)
      else $error("req word taken without ready");

endmodule

bind terrain_overlay_colorizer toc_checker u_toc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_red   (rsp_ch.red),
   .rsp_green (rsp_ch.green),
   .rsp_blue  (rsp_ch.blue),
   .rsp_alpha (rsp_ch.alpha)
);

// ===== sim/tb_terrain_overlay_colorizer.sv =====
`timescale 1ns / 1ps

module tb_terrain_overlay_colorizer;
   import toc_pkg::*;

   localparam int FRAC_BITS = 12;
   localparam longint ONE_FX = longint'(1) << FRAC_BITS;
   localparam longint PI_Q28 = 64'd843314857;
   localparam longint PI_FX = (PI_Q28 + (longint'(1) << (27 - FRAC_BITS))) >> (28 - FRAC_BITS);
   localparam int DRAIN_CYCLES = 2 * (FRAC_BITS + 4);
   localparam int HOLD_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_TILES = 570;
   localparam int NUM_DIRECTED = 23;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MODE = {REG_MODE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_DMAX = {REG_DMAX, 2'b00};
   localparam logic [3:0] MODE_CODE_MAX = 4'hf;

   typedef struct {
      logic signed [15:0] height;
      logic signed [15:0] slope;
      band_type           band;
      logic [15:0]        distance;
      logic signed [15:0] roughness;
      logic signed [15:0] aspect;
      logic signed [15:0] erodibility;
      logic signed [15:0] soil;
   } tile_type;

   typedef struct {
      bit        given;
      pixel_type px;
   } known_pixel_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [15:0] dmax;
      logic [15:0] value;
      logic        given;
      pixel_type   px;
   } tile_case_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   toc_req_if req_ch ();
   toc_rsp_if rsp_ch ();

   terrain_overlay_colorizer #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [3:0]  mode_reg = MODE_NONE;
   logic [15:0] dmax_reg = DMAX_RESET;
   pixel_type       expected_pixels[$];
   known_pixel_type known_pixels[$];

   int errors = 0;
   int tiles_accepted = 0;
   int pixels_predicted = 0;
   int pixels_checked = 0;
   int csr_writes = 0;
   int stall_cycles = 0;
   int idle_cycles = 0;
   int tx_style = 1;
   int rx_style = 1;
   bit hold_request = 0;
   int hold_left = 0;
   int rx_roll;

   tile_case_type directed_cases [NUM_DIRECTED] = '{
      '{MODE_NONE, DMAX_RESET, 16'h1234, 1'b1, '0},
      '{MODE_HEIGHT, DMAX_RESET, 16'h8000, 1'b1, '{8'd0, 8'd0, 8'd0, ALPHA_RAMP}},
      '{MODE_HEIGHT, DMAX_RESET, 16'h7fff, 1'b1, '{8'd255, 8'd255, 8'd255, ALPHA_RAMP}},
      '{MODE_SLOPE, DMAX_RESET, 16'h7fff, 1'b1, '{8'd255, 8'd230, 8'd0, ALPHA_RAMP}},
      '{MODE_BAND, DMAX_RESET, 16'd0, 1'b1, '{8'd30, 8'd60, 8'd180, ALPHA_FLAT}},
      '{MODE_BAND, DMAX_RESET, 16'd1, 1'b1, '{8'd120, 8'd180, 8'd80, ALPHA_FLAT}},
      '{MODE_BAND, DMAX_RESET, 16'd2, 1'b1, '{8'd200, 8'd170, 8'd80, ALPHA_FLAT}},
      '{MODE_BAND, DMAX_RESET, 16'd3, 1'b1, '{8'd180, 8'd180, 8'd190, ALPHA_FLAT}},
      '{MODE_DISTANCE, DMAX_RESET, 16'd0, 1'b1, '{8'd20, 8'd240, 8'd30, ALPHA_RAMP}},
      '{MODE_DISTANCE, DMAX_RESET, 16'hffff, 1'b1, '{8'd240, 8'd20, 8'd30, ALPHA_RAMP}},
      '{MODE_DISTANCE, 16'd0, 16'hffff, 1'b1, '{8'd20, 8'd240, 8'd30, ALPHA_RAMP}},
      '{MODE_DISTANCE, 16'hffff, 16'hffff, 1'b1, '{8'd240, 8'd20, 8'd30, ALPHA_RAMP}},
      '{MODE_ROUGHNESS, 16'hffff, 16'h8000, 1'b1, '{8'd0, 8'd0, 8'd20, ALPHA_RAMP}},
      '{MODE_ASPECT, 16'hffff, 16'h8000, 1'b1, '{8'd255, 8'd0, 8'd0, ALPHA_RAMP}},
      '{MODE_ASPECT, 16'hffff, 16'h7fff, 1'b1, '{8'd255, 8'd0, 8'd0, ALPHA_RAMP}},
      '{MODE_ASPECT, 16'hffff, -16'sd6579, 1'b0, '0},
      '{MODE_ASPECT, 16'hffff, 16'd1999, 1'b0, '0},
      '{MODE_ASPECT, 16'hffff, 16'd10577, 1'b0, '0},
      '{MODE_ERODIBILITY, 16'hffff, 16'h8000, 1'b1, '{8'd40, 8'd180, 8'd60, ALPHA_FLAT}},
      '{MODE_ERODIBILITY, 16'hffff, 16'h7fff, 1'b1, '{8'd200, 8'd80, 8'd60, ALPHA_FLAT}},
      '{MODE_SOIL, 16'hffff, 16'h8000, 1'b1, '{8'd220, 8'd200, 8'd140, ALPHA_FLAT}},
      '{MODE_SOIL, 16'hffff, 16'h7fff, 1'b1, '{8'd80, 8'd60, 8'd30, ALPHA_FLAT}},
      '{MODE_CODE_MAX, 16'hffff, 16'h4321, 1'b1, '0}
   };

   function automatic longint unit_frac(input longint v);
      if (v < 0) return 0;
      if (v > ONE_FX) return ONE_FX;
      return v;
   endfunction

   function automatic logic [7:0] frac_scale(input longint t, input longint k);
      return 8'((t * k) >> FRAC_BITS);
   endfunction

   function automatic logic [7:0] frac_lerp(input longint t, input longint a, input longint b);
      return 8'((a * (ONE_FX - t) + b * t) >> FRAC_BITS);
   endfunction

   // returns 0 when the mode gives no pixel
   function automatic bit colorize_tile(input logic [3:0] mode, input logic [15:0] dmax,
                                        input tile_type tl, output pixel_type px);
      longint t, u, h, f, q, d;
      logic [7:0] up, dn;
      px = '0;
      case (mode_type'(mode))
         MODE_HEIGHT: begin
            t = unit_frac(longint'(tl.height));
            px = '{frac_scale(t, 255), frac_scale(t, 255), frac_scale(t, 255), ALPHA_RAMP};
         end
         MODE_SLOPE, MODE_ROUGHNESS: begin
            t = unit_frac(longint'(mode == MODE_SLOPE ? tl.slope : tl.roughness));
            px = '{frac_scale(t, 255), frac_scale(t, 230), frac_scale(ONE_FX - t, 20),
                   ALPHA_RAMP};
         end
         MODE_BAND: begin
            case (tl.band)
               BAND_WATER:   px = '{8'd30, 8'd60, 8'd180, ALPHA_FLAT};
               BAND_LOWLAND: px = '{8'd120, 8'd180, 8'd80, ALPHA_FLAT};
               BAND_HILLS:   px = '{8'd200, 8'd170, 8'd80, ALPHA_FLAT};
               default:      px = '{8'd180, 8'd180, 8'd190, ALPHA_FLAT};
            endcase
         end
         MODE_DISTANCE: begin
            if (dmax == 0) begin
               t = 0;
            end else begin
               q = (longint'(tl.distance) << FRAC_BITS) / longint'(dmax);
               t = (q > ONE_FX) ? ONE_FX : q;
            end
            px = '{frac_scale(t, 220) + 8'd20, frac_scale(ONE_FX - t, 220) + 8'd20, 8'd30,
                   ALPHA_RAMP};
         end
         MODE_ASPECT: begin
            u = longint'(tl.aspect) + PI_FX;
            if (u < 0) u = 0;
            if (u > 2 * PI_FX) u = 2 * PI_FX;
            h = (u * 3 * ONE_FX) / PI_FX;
            if (h >= 6 * ONE_FX) h = h - 6 * ONE_FX;
            f = h & (ONE_FX - 1);
            up = frac_scale(f, 255);
            dn = frac_scale(ONE_FX - f, 255);
            px.alpha = ALPHA_RAMP;
            case (sector_type'(h >> FRAC_BITS))
               SEC_RED:    begin px.red = 8'd255; px.green = up; end
               SEC_YELLOW: begin px.red = dn; px.green = 8'd255; end
               SEC_GREEN:  begin px.green = 8'd255; px.blue = up; end
               SEC_CYAN:   begin px.green = dn; px.blue = 8'd255; end
               SEC_BLUE:   begin px.red = up; px.blue = 8'd255; end
               default:    begin px.red = 8'd255; px.blue = dn; end
            endcase
         end
         MODE_ERODIBILITY: begin
            t = unit_frac(longint'(tl.erodibility));
            px = '{frac_lerp(t, 40, 200), frac_lerp(t, 180, 80), frac_lerp(t, 60, 60),
                   ALPHA_FLAT};
         end
         MODE_SOIL: begin
            d = longint'(tl.soil);
            t = (d <= 0) ? 0 : unit_frac(d / 3);
            px = '{frac_lerp(t, 220, 80), frac_lerp(t, 200, 60), frac_lerp(t, 140, 30),
                   ALPHA_FLAT};
         end
         default: return 0;
      endcase
      return 1;
   endfunction

   // inside [lo, hi] half the time, with extremes and full-range noise mixed in
   function automatic logic [15:0] pick_value(input int lo, input int hi);
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         4, 5: return 16'($urandom);
         default: return 16'(lo + int'($urandom_range(0, hi - lo)));
      endcase
   endfunction

   function automatic tile_type random_tile(input logic [15:0] dmax);
      tile_type tl;
      int dist_hi;
      dist_hi = 2 * int'(dmax) + 16;
      if (dist_hi > 65535) dist_hi = 65535;
      tl.height = pick_value(-200, 4300);
      tl.slope = pick_value(-200, 4300);
      tl.band = band_type'($urandom_range(0, 3));
      tl.distance = pick_value(0, dist_hi);
      tl.roughness = pick_value(-200, 4300);
      tl.aspect = pick_value(-13000, 13000);
      tl.erodibility = pick_value(-200, 4300);
      tl.soil = pick_value(-300, 12600);
      return tl;
   endfunction

   task automatic send_tile(input tile_type tl);
      req_ch.valid <= 1'b1;
      req_ch.height_value <= tl.height;
      req_ch.slope_value <= tl.slope;
      req_ch.band_code <= tl.band;
      req_ch.ocean_distance <= tl.distance;
      req_ch.roughness_value <= tl.roughness;
      req_ch.aspect_angle <= tl.aspect;
      req_ch.erodibility_value <= tl.erodibility;
      req_ch.soil_depth_value <= tl.soil;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic rest_sender();
      int gap;
      int roll;
      gap = 0;
      roll = $urandom_range(0, 99);
      if (tx_style != 0) begin
         if (roll >= 90) gap = $urandom_range(8, 30);
         else if (roll >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_overlay(input logic [3:0] mode, input logic [15:0] dmax);
      csr_write(ADDR_MODE, ($urandom & ~32'hf) | 32'(mode));
      csr_write(ADDR_DMAX, ($urandom & ~32'hffff) | 32'(dmax));
   endtask

   task automatic check_channel(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // register copy and tile prediction
   always @(posedge clock) begin : predict_block
      tile_type tl;
      pixel_type px;
      known_pixel_type kp;
      if (reset) begin
         mode_reg = MODE_NONE;
         dmax_reg = DMAX_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            csr_writes++;
            if (csr_paddr == ADDR_MODE) mode_reg = csr_pwdata[3:0];
            else if (csr_paddr == ADDR_DMAX) dmax_reg = csr_pwdata[15:0];
         end
         if (req_ch.valid && !req_ch.ready) stall_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            tl.height = req_ch.height_value;
            tl.slope = req_ch.slope_value;
            tl.band = band_type'(req_ch.band_code);
            tl.distance = req_ch.ocean_distance;
            tl.roughness = req_ch.roughness_value;
            tl.aspect = req_ch.aspect_angle;
            tl.erodibility = req_ch.erodibility_value;
            tl.soil = req_ch.soil_depth_value;
            kp.given = 1'b0;
            kp.px = '0;
            if (known_pixels.size() != 0) kp = known_pixels.pop_front();
            if (colorize_tile(mode_reg, dmax_reg, tl, px)) begin
               expected_pixels = {expected_pixels, (kp.given ? kp.px : px)};
               pixels_predicted++;
            end
            tiles_accepted++;
         end
      end
   end

   always @(posedge clock) begin : check_block
      pixel_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("overlay pixel %0h %0h %0h %0h with no tile waiting",
                   rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            check_channel("red", want.red, rsp_ch.red);
            check_channel("green", want.green, rsp_ch.green);
            check_channel("blue", want.blue, rsp_ch.blue);
            check_channel("alpha", want.alpha, rsp_ch.alpha);
            pixels_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rx_style == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 20) begin
               hold_left = $urandom_range(0, 2);
               rsp_ch.ready <= 1'b0;
            end else if (rx_roll < 22) begin
               hold_left = $urandom_range(10, 40);
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   initial begin : main_block
      tile_type tl;
      tile_case_type tc;
      logic [3:0] mode;
      logic [15:0] dmax;
      int sent;
      int phase;
      int count;
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.height_value <= '0;
      req_ch.slope_value <= '0;
      req_ch.band_code <= '0;
      req_ch.ocean_distance <= '0;
      req_ch.roughness_value <= '0;
      req_ch.aspect_angle <= '0;
      req_ch.erodibility_value <= '0;
      req_ch.soil_depth_value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         tc = directed_cases[i];
         if (tc.mode != mode_reg || tc.dmax != dmax_reg) begin
            wait_drained();
            set_overlay(tc.mode, tc.dmax);
         end
         tl = random_tile(tc.dmax);
         case (mode_type'(tc.mode))
            MODE_HEIGHT:      tl.height = tc.value;
            MODE_SLOPE:       tl.slope = tc.value;
            MODE_BAND:        tl.band = band_type'(tc.value[1:0]);
            MODE_DISTANCE:    tl.distance = tc.value;
            MODE_ROUGHNESS:   tl.roughness = tc.value;
            MODE_ASPECT:      tl.aspect = tc.value;
            MODE_ERODIBILITY: tl.erodibility = tc.value;
            MODE_SOIL:        tl.soil = tc.value;
            default: ;
         endcase
         known_pixels = {known_pixels, known_pixel_type'{tc.given, tc.px}};
         send_tile(tl);
         rest_sender();
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_TILES) begin
         wait_drained();
         case ($urandom_range(0, 9))
            8: mode = MODE_NONE;
            9: mode = 4'($urandom_range(MODE_SOIL + 1, MODE_CODE_MAX));
            default: mode = 4'($urandom_range(MODE_HEIGHT, MODE_SOIL));
         endcase
         case ($urandom_range(0, 5))
            0: dmax = 16'd0;
            1: dmax = 16'd1;
            2: dmax = DMAX_RESET;
            3: dmax = 16'hffff;
            4: dmax = 16'($urandom_range(1, 512));
            default: dmax = 16'($urandom);
         endcase
         tx_style = ($urandom_range(0, 2) != 0);
         rx_style = ($urandom_range(0, 2) != 0);
         count = $urandom_range(20, 60);
         if (phase == 2) begin
            // hold the result side off long enough to back up the whole pipeline
            mode = 4'($urandom_range(MODE_HEIGHT, MODE_SOIL));
            tx_style = 0;
            rx_style = 1;
            count = 60;
         end
         set_overlay(mode, dmax);
         if (phase == 2) hold_request = 1'b1;
         repeat (count) begin
            tl = random_tile(dmax_reg);
            known_pixels = {known_pixels, known_pixel_type'{1'b0, '0}};
            send_tile(tl);
            rest_sender();
         end
         sent += count;
         phase++;
      end

      wait_drained();
      $display("%0d tiles over %0d random phases and %0d register writes, %0d pixels checked",
               tiles_accepted, phase, csr_writes, pixels_checked);
      $display("tile input held off on %0d cycles by result back-pressure", stall_cycles);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
